FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros check on the rising clock
// edge and stay quiet while reset is asserted (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/atdmd_pkg.sv
package atdmd_pkg;

    localparam int VOLUME_BITS = 7;
    localparam int PERIOD_BITS = 17;
    localparam int ACC60_BITS  = 15;
    localparam int ACC10_BITS  = 17;
    localparam int DEPTH_BITS  = 8;
    localparam int STEPS_BITS  = 3;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    // Request kinds.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PAUSE  = 2'd1;
    localparam logic [1:0] KIND_RESUME = 2'd2;

    // Register index taken from paddr[2].
    localparam logic REG_TICK_PERIOD = 1'b0;

    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX_US   = 17'd100000;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET_US = 17'd20000;
    localparam logic [ACC10_BITS:0]    STEP_10HZ_US    = 18'd100000;
    localparam logic [ACC60_BITS-1:0]  STEP_60HZ_US    = 15'd16667;
    localparam int                     MAX_FADE_STEPS  = 6;

    // Multiples of the 60 Hz step, used to find the step count in one compare row.
    localparam logic [PERIOD_BITS-1:0] STEP60_MULT [0:MAX_FADE_STEPS] = '{
        17'd0, 17'd16667, 17'd33334, 17'd50001, 17'd66668, 17'd83335, 17'd100002
    };

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = 8'd255;

    localparam int DUCK_RISE    = 3;
    localparam int DUCK_FALL    = 18;
    localparam int SPEECH_NUM   = 80;
    localparam int SPEECH_SHIFT = 7;

    typedef struct packed {
        logic [1:0]             kind;
        logic                   speech_active;
        logic [VOLUME_BITS-1:0] music_volume;
    } in_item_t;

    typedef struct packed {
        logic [STEPS_BITS-1:0]  fade_steps;
        logic                   duck_updated;
        logic [VOLUME_BITS-1:0] effective_volume;
        logic [DEPTH_BITS-1:0]  pause_depth;
    } out_item_t;

endpackage

FILE: sv/atdmd_duck.sv
module atdmd_duck (
    input  logic [atdmd_pkg::VOLUME_BITS-1:0] eff_volume,
    input  logic [atdmd_pkg::VOLUME_BITS-1:0] music_volume,
    input  logic                              speech_active,
    output logic [atdmd_pkg::VOLUME_BITS-1:0] new_volume
);

    localparam int VB = atdmd_pkg::VOLUME_BITS;
    localparam int W  = VB + 2;
    localparam int PW = VB + atdmd_pkg::SPEECH_SHIFT;
    localparam logic signed [W-1:0] RISE = W'(atdmd_pkg::DUCK_RISE);
    localparam logic signed [W-1:0] FALL = W'(atdmd_pkg::DUCK_FALL);

    logic [PW-1:0]         speech_prod;
    logic signed [W-1:0]   target;
    logic signed [W-1:0]   e_cur;
    logic signed [W-1:0]   e_mov;
    logic signed [W-1:0]   v_in;
    logic signed [W-1:0]   v_out;

    assign speech_prod = PW'(music_volume) * PW'(atdmd_pkg::SPEECH_NUM);
    assign e_cur       = W'(eff_volume);
    assign v_in        = W'(music_volume);

    always_comb begin
        // Speech ducks the music target to 80/128 of its setting.
        if (speech_active) begin
            target = W'(speech_prod[PW-1:atdmd_pkg::SPEECH_SHIFT]);
        end else begin
            target = v_in;
        end

        v_out = v_in;
        if (e_cur < v_in) begin
            e_mov = e_cur + RISE;
            if (e_mov >= target) begin
                if (v_in <= target) begin
                    v_out = target;
                end
            end else begin
                if (v_in <= e_mov) begin
                    v_out = e_mov;
                end
            end
        end else begin
            e_mov = e_cur - FALL;
            if (e_mov > target) begin
                if (v_in >= e_mov) begin
                    v_out = e_mov;
                end
            end else begin
                if (v_in >= target) begin
                    v_out = target;
                end
            end
        end

        if (v_out < 0) begin
            new_volume = '0;
        end else begin
            new_volume = v_out[VB-1:0];
        end
    end

endmodule

FILE: sv/audio_tick_divider_and_music_ducker_unit.sv
// Channel   Ports                      Carries
// -------   ------------------------   ----------------------------------------
// input     s_valid s_ready s_data     tick, pause or resume request
// result    m_valid m_ready m_data     fade steps, duck flag, volume, pause depth
// config    psel penable pwrite ...    tick_period_us at byte address 0
//
// A request is held in the input register and is worked out in a single pass
// into the result register; one request per cycle is sustained while m_ready
// stays high. The single pass covers the accumulate, compare row and ducking step.
// Reset (aresetn low, synchronous) clears both accumulators and the pause depth,
// sets the effective volume to full scale and the tick period to 20000 us.
// When m_ready is low the result holds, and the input register fills and then
// holds s_ready low until the result is taken.
`include "assert_macros.svh"

module audio_tick_divider_and_music_ducker_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  atdmd_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output atdmd_pkg::out_item_t                m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [atdmd_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [atdmd_pkg::DATA_BITS-1:0]     pwdata,
    output logic [atdmd_pkg::DATA_BITS-1:0]     prdata,
    output logic                                pready
);

    localparam int PB = atdmd_pkg::PERIOD_BITS;
    localparam int A6 = atdmd_pkg::ACC60_BITS;
    localparam int A1 = atdmd_pkg::ACC10_BITS;
    localparam int VB = atdmd_pkg::VOLUME_BITS;
    localparam int DB = atdmd_pkg::DEPTH_BITS;
    localparam int SB = atdmd_pkg::STEPS_BITS;

    logic                      in_valid_reg;
    atdmd_pkg::in_item_t       in_data_reg;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    atdmd_pkg::out_item_t      m_data_reg;
    atdmd_pkg::out_item_t      m_data_next;

    logic [PB-1:0]             period_reg;
    logic [PB-1:0]             period_next;
    logic [A6-1:0]             acc60_reg;
    logic [A6-1:0]             acc60_next;
    logic [A1-1:0]             acc10_reg;
    logic [A1-1:0]             acc10_next;
    logic [VB-1:0]             eff_vol_reg;
    logic [VB-1:0]             eff_vol_next;
    logic [DB-1:0]             pause_reg;
    logic [DB-1:0]             pause_next;

    logic                      out_free;
    logic                      advance;
    logic                      cfg_write;
    logic [PB-1:0]             wr_period;
    logic [PB-1:0]             sum60;
    logic [A1:0]               sum10;
    logic [PB-1:0]             sub60;
    logic [SB-1:0]             steps;
    logic                      ducked;
    logic [VB-1:0]             duck_vol;

    atdmd_duck u_duck (
        .eff_volume    (eff_vol_reg),
        .music_volume  (in_data_reg.music_volume),
        .speech_active (in_data_reg.speech_active),
        .new_volume    (duck_vol)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[2] == atdmd_pkg::REG_TICK_PERIOD);
    assign wr_period = pwdata[PB-1:0];
    assign prdata    = (paddr[2] == atdmd_pkg::REG_TICK_PERIOD) ?
                       atdmd_pkg::DATA_BITS'(period_reg) : '0;

    always_comb begin
        period_next = period_reg;
        if (cfg_write) begin
            if (wr_period > atdmd_pkg::PERIOD_MAX_US) begin
                period_next = atdmd_pkg::PERIOD_MAX_US;
            end else begin
                period_next = wr_period;
            end
        end
    end

    // Tick arithmetic: the step count is the largest k whose multiple of the 60 Hz
    // period is not above the sum, found by a row of independent compares.
    assign sum60 = PB'(acc60_reg) + period_reg;
    assign sum10 = (A1 + 1)'(acc10_reg) + (A1 + 1)'(period_reg);

    always_comb begin
        steps = '0;
        sub60 = '0;
        for (int k = 1; k <= atdmd_pkg::MAX_FADE_STEPS; k++) begin
            if (sum60 >= atdmd_pkg::STEP60_MULT[k]) begin
                steps = SB'(k);
                sub60 = atdmd_pkg::STEP60_MULT[k];
            end
        end
    end

    always_comb begin
        acc60_next   = acc60_reg;
        acc10_next   = acc10_reg;
        eff_vol_next = eff_vol_reg;
        pause_next   = pause_reg;
        ducked       = 1'b0;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (advance) begin
            case (in_data_reg.kind)
                atdmd_pkg::KIND_PAUSE: begin
                    if (pause_reg != atdmd_pkg::DEPTH_MAX) begin
                        pause_next = pause_reg + DB'(1);
                    end
                end
                atdmd_pkg::KIND_RESUME: begin
                    if (pause_reg != '0) begin
                        pause_next = pause_reg - DB'(1);
                    end
                end
                atdmd_pkg::KIND_TICK: begin
                    if (pause_reg == '0) begin
                        acc60_next = A6'(sum60 - sub60);
                        if (sum10 >= atdmd_pkg::STEP_10HZ_US) begin
                            acc10_next   = A1'(sum10 - atdmd_pkg::STEP_10HZ_US);
                            eff_vol_next = duck_vol;
                            ducked       = 1'b1;
                        end else begin
                            acc10_next = A1'(sum10);
                        end
                    end
                end
                default: begin
                end
            endcase

            m_data_next.fade_steps =
                (in_data_reg.kind == atdmd_pkg::KIND_TICK && pause_reg == '0) ? steps : '0;
            m_data_next.duck_updated     = ducked;
            m_data_next.effective_volume = eff_vol_next;
            m_data_next.pause_depth      = pause_next;
            m_valid_next                 = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            period_reg   <= atdmd_pkg::PERIOD_RESET_US;
            acc60_reg    <= '0;
            acc10_reg    <= '0;
            eff_vol_reg  <= '1;
            pause_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            m_valid_reg <= m_valid_next;
            period_reg  <= period_next;
            acc60_reg   <= acc60_next;
            acc10_reg   <= acc10_next;
            eff_vol_reg <= eff_vol_next;
            pause_reg   <= pause_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    `ASSERT_IMPLIES(a_acc60_range, aclk, aresetn, 1'b1, acc60_reg < atdmd_pkg::STEP_60HZ_US)
    `ASSERT_IMPLIES(a_acc10_range, aclk, aresetn, 1'b1, acc10_reg < A1'(atdmd_pkg::STEP_10HZ_US))
    `ASSERT_IMPLIES(a_steps_range, aclk, aresetn, m_valid_reg, m_data_reg.fade_steps <= SB'(atdmd_pkg::MAX_FADE_STEPS))
    `ASSERT_IMPLIES(a_duck_unpaused, aclk, aresetn, m_valid_reg && m_data_reg.duck_updated, m_data_reg.pause_depth == '0)
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg && $stable(m_data_reg))

endmodule
